// ===== hw/rtl/smt_pkg.sv =====
// smt_pkg: shared types and constants of the socket mailbox table
// used by smt_ctrl, smt_dp and socket_mailbox_table_top
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

  localparam int SOCKETS = 16;
  localparam int PORTS   = 16;
  localparam int SOCK_W  = $clog2(SOCKETS);
  localparam int PORT_W  = $clog2(PORTS);

  localparam int OP_W     = 3;
  localparam int CALLER_W = 16;
  localparam int IDX_W    = 5;
  localparam int MSG_W    = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN    = 3'd0,
    OP_BIND    = 3'd1,
    OP_CONNECT = 3'd2,
    OP_RECEIVE = 3'd3,
    OP_SEND    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_BAD_INDEX     = 3'd1,
    ST_CLOSED        = 3'd2,
    ST_NOT_CONNECTED = 3'd3,
    ST_REFUSED       = 3'd4,
    ST_FULL          = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smt_ctrl.sv =====
// smt_ctrl: request sequencer, handshakes and output valid
// depends on smt_pkg
`timescale 1ns / 1ps
`default_nettype none

module smt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output smt_pkg::cmd_t      cmd
);

  smt_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.commit     = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      smt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = smt_pkg::S_RESOLVE;
        end
      end
      smt_pkg::S_RESOLVE: begin
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = smt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = smt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smt_dp.sv =====
// smt_dp: socket and port tables, request decode and result registers
// depends on smt_pkg
`timescale 1ns / 1ps
`default_nettype none

module smt_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire smt_pkg::cmd_t                  cmd,
  input  wire logic [smt_pkg::OP_W-1:0]       opcode,
  input  wire logic [smt_pkg::CALLER_W-1:0]   caller_id,
  input  wire logic [smt_pkg::IDX_W-1:0]      socket_index,
  input  wire logic [smt_pkg::IDX_W-1:0]      port_number,
  input  wire logic [smt_pkg::MSG_W-1:0]      message_word,
  output logic      [smt_pkg::STATUS_W-1:0]   status_code,
  output logic      [smt_pkg::MSG_W-1:0]      result_value
);

  // tables
  logic [smt_pkg::SOCKETS-1:0]                       slot_open;
  logic [smt_pkg::SOCKETS-1:0]                       peer_valid;
  logic [smt_pkg::PORTS-1:0]                         port_bound;
  logic [smt_pkg::CALLER_W-1:0]                      slot_owner [smt_pkg::SOCKETS];
  logic [smt_pkg::SOCK_W-1:0]                        peer_slot  [smt_pkg::SOCKETS];
  logic [smt_pkg::MSG_W-1:0]                         mailbox    [smt_pkg::SOCKETS];
  logic [smt_pkg::SOCK_W-1:0]                        port_slot  [smt_pkg::PORTS];
  logic [smt_pkg::SOCK_W:0]                          next_free_slot;

  // latched request and first lookup
  logic [smt_pkg::OP_W-1:0]     op_r;
  logic [smt_pkg::CALLER_W-1:0] caller_r;
  logic [smt_pkg::IDX_W-1:0]    s_r;
  logic [smt_pkg::IDX_W-1:0]    p_r;
  logic [smt_pkg::MSG_W-1:0]    msg_r;
  logic                         s_open_r;
  logic [smt_pkg::CALLER_W-1:0] s_owner_r;
  logic                         s_peer_valid_r;
  logic [smt_pkg::SOCK_W-1:0]   s_peer_slot_r;
  logic [smt_pkg::MSG_W-1:0]    s_mail_r;
  logic                         p_bound_r;
  logic [smt_pkg::SOCK_W-1:0]   p_slot_r;

  logic [smt_pkg::SOCK_W-1:0] s_idx;
  logic [smt_pkg::PORT_W-1:0] p_idx;
  logic [smt_pkg::SOCK_W-1:0] x_idx;
  logic [smt_pkg::SOCK_W-1:0] raddr;
  logic [smt_pkg::SOCK_W-1:0] n_idx;
  logic                       rd_open;
  logic                       rd_peer_valid;
  logic [smt_pkg::MSG_W-1:0]  rd_mail;

  smt_pkg::status_t           st;
  smt_pkg::status_t           st_chk;
  logic [smt_pkg::MSG_W-1:0]  val;
  logic                       s_bad;
  logic                       p_bad;
  logic                       we_open;
  logic                       we_port;
  logic                       we_conn;
  logic                       we_mail;
  logic [smt_pkg::SOCK_W-1:0] mail_addr;
  logic [smt_pkg::MSG_W-1:0]  mail_data;

  assign s_idx = s_r[smt_pkg::SOCK_W-1:0];
  assign p_idx = p_r[smt_pkg::PORT_W-1:0];
  assign n_idx = next_free_slot[smt_pkg::SOCK_W-1:0];

  // second lookup: bound socket on connect, peer on send
  assign x_idx = (op_r == smt_pkg::OP_CONNECT) ? p_slot_r : s_peer_slot_r;
  assign raddr = cmd.load ? socket_index[smt_pkg::SOCK_W-1:0] : x_idx;

  assign rd_open       = slot_open[raddr];
  assign rd_peer_valid = peer_valid[raddr];
  assign rd_mail       = mailbox[raddr];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r           <= opcode;
      caller_r       <= caller_id;
      s_r            <= socket_index;
      p_r            <= port_number;
      msg_r          <= message_word;
      s_open_r       <= rd_open;
      s_owner_r      <= slot_owner[raddr];
      s_peer_valid_r <= rd_peer_valid;
      s_peer_slot_r  <= peer_slot[raddr];
      s_mail_r       <= rd_mail;
      p_bound_r      <= port_bound[port_number[smt_pkg::PORT_W-1:0]];
      p_slot_r       <= port_slot[port_number[smt_pkg::PORT_W-1:0]];
    end
  end

  assign s_bad = 32'(s_r) >= smt_pkg::SOCKETS;
  assign p_bad = 32'(p_r) >= smt_pkg::PORTS;

  always_comb begin
    if (s_bad) begin
      st_chk = smt_pkg::ST_BAD_INDEX;
    end else if (!s_open_r) begin
      st_chk = smt_pkg::ST_CLOSED;
    end else begin
      st_chk = smt_pkg::ST_OK;
    end
  end

  always_comb begin
    st        = smt_pkg::ST_OK;
    val       = '0;
    we_open   = 1'b0;
    we_port   = 1'b0;
    we_conn   = 1'b0;
    we_mail   = 1'b0;
    mail_addr = s_idx;
    mail_data = '0;
    case (op_r)
      smt_pkg::OP_OPEN: begin
        if (next_free_slot >= (smt_pkg::SOCK_W+1)'(smt_pkg::SOCKETS)) begin
          st = smt_pkg::ST_FULL;
        end else begin
          we_open   = 1'b1;
          we_mail   = 1'b1;
          mail_addr = n_idx;
          val       = smt_pkg::MSG_W'(next_free_slot);
        end
      end
      smt_pkg::OP_BIND: begin
        if (st_chk != smt_pkg::ST_OK) begin
          st = st_chk;
        end else if (p_bad) begin
          st = smt_pkg::ST_BAD_INDEX;
        end else if (p_bound_r) begin
          st = smt_pkg::ST_REFUSED;
        end else begin
          we_port = 1'b1;
        end
      end
      smt_pkg::OP_CONNECT: begin
        if (st_chk != smt_pkg::ST_OK) begin
          st = st_chk;
        end else if (p_bad) begin
          st = smt_pkg::ST_BAD_INDEX;
        end else if (!p_bound_r || !rd_open || rd_peer_valid) begin
          st = smt_pkg::ST_REFUSED;
        end else begin
          we_conn = 1'b1;
        end
      end
      smt_pkg::OP_RECEIVE: begin
        if (st_chk != smt_pkg::ST_OK) begin
          st = st_chk;
        end else if (s_owner_r != caller_r) begin
          st = smt_pkg::ST_REFUSED;
        end else begin
          val     = s_mail_r;
          we_mail = 1'b1;
        end
      end
      smt_pkg::OP_SEND: begin
        if (st_chk != smt_pkg::ST_OK) begin
          st = st_chk;
        end else if (!s_peer_valid_r) begin
          st = smt_pkg::ST_NOT_CONNECTED;
        end else if (s_owner_r != caller_r || rd_mail != '0) begin
          st = smt_pkg::ST_REFUSED;
        end else begin
          we_mail   = 1'b1;
          mail_addr = s_peer_slot_r;
          mail_data = msg_r;
        end
      end
      default: begin
        st = smt_pkg::ST_REFUSED;
      end
    endcase
  end

  // flags and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open      <= '0;
      peer_valid     <= '0;
      port_bound     <= '0;
      next_free_slot <= '0;
    end else if (cmd.commit) begin
      if (we_open) begin
        slot_open[n_idx]  <= 1'b1;
        peer_valid[n_idx] <= 1'b0;
        next_free_slot    <= next_free_slot + 1'b1;
      end
      if (we_port) begin
        port_bound[p_idx] <= 1'b1;
      end
      if (we_conn) begin
        peer_valid[p_slot_r] <= 1'b1;
        peer_valid[s_idx]    <= 1'b1;
      end
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (we_open) begin
        slot_owner[n_idx] <= caller_r;
      end
      if (we_port) begin
        port_slot[p_idx] <= s_idx;
      end
      if (we_conn) begin
        peer_slot[p_slot_r] <= s_idx;
        peer_slot[s_idx]    <= p_slot_r;
      end
      if (we_mail) begin
        mailbox[mail_addr] <= mail_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_code  <= st;
      result_value <= val;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/socket_mailbox_table_top.sv =====
// socket_mailbox_table_top: one request in, one status and value out per item.
// out_valid is registered; it rises when S_RESOLVE commits on a free output.
// A new item is taken only in S_IDLE, after the last one commits; two lookups
// (addressed socket, then bound or peer socket) share one socket-table read path.
// Reset: synchronous, clears open, peer and port flags and the fill count at once.
// depends on smt_pkg, smt_ctrl, smt_dp
`timescale 1ns / 1ps
`default_nettype none

module socket_mailbox_table_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [smt_pkg::OP_W-1:0]       opcode,
  input  wire logic [smt_pkg::CALLER_W-1:0]   caller_id,
  input  wire logic [smt_pkg::IDX_W-1:0]      socket_index,
  input  wire logic [smt_pkg::IDX_W-1:0]      port_number,
  input  wire logic [smt_pkg::MSG_W-1:0]      message_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [smt_pkg::STATUS_W-1:0]   status_code,
  output logic      [smt_pkg::MSG_W-1:0]      result_value
);

  smt_pkg::cmd_t cmd;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  smt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .caller_id    (caller_id),
    .socket_index (socket_index),
    .port_number  (port_number),
    .message_word (message_word),
    .status_code  (status_code),
    .result_value (result_value)
  );

endmodule

`default_nettype wire

// ===== tb/socket_mailbox_table_top_test.sv =====
// socket_mailbox_table_top_test: self-checking bench for the socket mailbox table
// drives open/bind/connect/send/receive items, predicts each status and value, checks in order
// depends on smt_pkg and socket_mailbox_table_top
`timescale 1ns / 1ps

module socket_mailbox_table_top_test;

  localparam int OP_MAX         = (1 << smt_pkg::OP_W) - 1;
  localparam int IDX_MAX        = (1 << smt_pkg::IDX_W) - 1;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [smt_pkg::OP_W-1:0]     op;
    logic [smt_pkg::CALLER_W-1:0] who;
    logic [smt_pkg::IDX_W-1:0]    sock;
    logic [smt_pkg::IDX_W-1:0]    port;
    logic [smt_pkg::MSG_W-1:0]    msg;
  } smt_req_t;

  typedef struct {
    smt_pkg::status_t          status;
    logic [smt_pkg::MSG_W-1:0] value;
  } smt_res_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [smt_pkg::OP_W-1:0]     opcode = '0;
  logic [smt_pkg::CALLER_W-1:0] caller_id = '0;
  logic [smt_pkg::IDX_W-1:0]    socket_index = '0;
  logic [smt_pkg::IDX_W-1:0]    port_number = '0;
  logic [smt_pkg::MSG_W-1:0]    message_word = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [smt_pkg::STATUS_W-1:0] status_code;
  logic [smt_pkg::MSG_W-1:0]    result_value;

  // predicted table contents
  bit                         sk_open[smt_pkg::SOCKETS];
  bit [smt_pkg::CALLER_W-1:0] sk_owner[smt_pkg::SOCKETS];
  bit                         sk_paired[smt_pkg::SOCKETS];
  int                         sk_peer[smt_pkg::SOCKETS];
  bit [smt_pkg::MSG_W-1:0]    sk_box[smt_pkg::SOCKETS];
  bit                         pt_bound[smt_pkg::PORTS];
  int                         pt_sock[smt_pkg::PORTS];
  int                         sk_fill;

  // owners as known when the items are built
  bit [smt_pkg::CALLER_W-1:0] gen_owner[smt_pkg::SOCKETS];
  int                         gen_fill;
  bit [smt_pkg::CALLER_W-1:0] caller_pool[4];

  smt_req_t req_q[$];
  smt_res_t due_q[$];
  smt_req_t next_req;
  smt_res_t want;

  int gap_odds;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_go;
  bit hold_done;
  bit in_took;
  bit out_took;
  int idle_cycles;
  int accepted;
  int results;
  int mismatches;
  int status_seen[1 << smt_pkg::STATUS_W];

  socket_mailbox_table_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .caller_id    (caller_id),
    .socket_index (socket_index),
    .port_number  (port_number),
    .message_word (message_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status_code  (status_code),
    .result_value (result_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic smt_pkg::status_t slot_status(logic [smt_pkg::IDX_W-1:0] s);
    if (s >= smt_pkg::SOCKETS) return smt_pkg::ST_BAD_INDEX;
    if (!sk_open[s]) return smt_pkg::ST_CLOSED;
    return smt_pkg::ST_OK;
  endfunction

  function automatic smt_res_t mailbox_table_apply(
      logic [smt_pkg::OP_W-1:0] op,
      logic [smt_pkg::CALLER_W-1:0] who,
      logic [smt_pkg::IDX_W-1:0] s,
      logic [smt_pkg::IDX_W-1:0] p,
      logic [smt_pkg::MSG_W-1:0] msg);
    smt_res_t r;
    int       t;
    r.status = smt_pkg::ST_OK;
    r.value  = '0;
    case (op)
      smt_pkg::OP_OPEN: begin
        if (sk_fill >= smt_pkg::SOCKETS) begin
          r.status = smt_pkg::ST_FULL;
        end else begin
          sk_open[sk_fill]   = 1'b1;
          sk_owner[sk_fill]  = who;
          sk_paired[sk_fill] = 1'b0;
          sk_peer[sk_fill]   = 0;
          sk_box[sk_fill]    = '0;
          r.value            = sk_fill;
          sk_fill++;
        end
      end
      smt_pkg::OP_BIND: begin
        r.status = slot_status(s);
        if (r.status == smt_pkg::ST_OK) begin
          if (p >= smt_pkg::PORTS) r.status = smt_pkg::ST_BAD_INDEX;
          else if (pt_bound[p]) r.status = smt_pkg::ST_REFUSED;
          else begin
            pt_bound[p] = 1'b1;
            pt_sock[p]  = int'(s);
          end
        end
      end
      smt_pkg::OP_CONNECT: begin
        r.status = slot_status(s);
        if (r.status == smt_pkg::ST_OK) begin
          if (p >= smt_pkg::PORTS) r.status = smt_pkg::ST_BAD_INDEX;
          else if (!pt_bound[p]) r.status = smt_pkg::ST_REFUSED;
          else begin
            t = pt_sock[p];
            if (!sk_open[t] || sk_paired[t]) begin
              r.status = smt_pkg::ST_REFUSED;
            end else begin
              sk_paired[t] = 1'b1;
              sk_peer[t]   = int'(s);
              sk_paired[s] = 1'b1;
              sk_peer[s]   = t;
            end
          end
        end
      end
      smt_pkg::OP_RECEIVE: begin
        r.status = slot_status(s);
        if (r.status == smt_pkg::ST_OK) begin
          if (sk_owner[s] != who) begin
            r.status = smt_pkg::ST_REFUSED;
          end else begin
            r.value   = sk_box[s];
            sk_box[s] = '0;
          end
        end
      end
      smt_pkg::OP_SEND: begin
        r.status = slot_status(s);
        if (r.status == smt_pkg::ST_OK) begin
          if (!sk_paired[s]) begin
            r.status = smt_pkg::ST_NOT_CONNECTED;
          end else begin
            t = sk_peer[s];
            if (sk_owner[s] != who || sk_box[t] != '0) r.status = smt_pkg::ST_REFUSED;
            else sk_box[t] = msg;
          end
        end
      end
      default: r.status = smt_pkg::ST_REFUSED;
    endcase
    return r;
  endfunction

  task automatic push_req(logic [smt_pkg::OP_W-1:0] op, logic [smt_pkg::CALLER_W-1:0] who,
                          logic [smt_pkg::IDX_W-1:0] s, logic [smt_pkg::IDX_W-1:0] p,
                          logic [smt_pkg::MSG_W-1:0] msg);
    smt_req_t q;
    q.op   = op;
    q.who  = who;
    q.sock = s;
    q.port = p;
    q.msg  = msg;
    if (op == smt_pkg::OP_OPEN && gen_fill < smt_pkg::SOCKETS) begin
      gen_owner[gen_fill] = who;
      gen_fill++;
    end
    req_q.push_back(q);
  endtask

  // mostly owner-correct requests on opened slots, with some noise
  task automatic push_random(int n);
    logic [smt_pkg::OP_W-1:0]     op;
    logic [smt_pkg::CALLER_W-1:0] who;
    logic [smt_pkg::IDX_W-1:0]    s;
    logic [smt_pkg::IDX_W-1:0]    p;
    logic [smt_pkg::MSG_W-1:0]    msg;
    int                           r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) op = smt_pkg::OP_OPEN;
      else if (r < 18) op = smt_pkg::OP_BIND;
      else if (r < 33) op = smt_pkg::OP_CONNECT;
      else if (r < 63) op = smt_pkg::OP_RECEIVE;
      else if (r < 95) op = smt_pkg::OP_SEND;
      else op = smt_pkg::OP_W'($urandom_range(smt_pkg::OP_SEND + 1, OP_MAX));
      if ($urandom_range(0, 15) == 0)
        s = smt_pkg::IDX_W'($urandom_range(smt_pkg::SOCKETS, IDX_MAX));
      else if (gen_fill > 0 && $urandom_range(0, 3) != 0)
        s = smt_pkg::IDX_W'($urandom_range(0, gen_fill - 1));
      else s = smt_pkg::IDX_W'($urandom_range(0, smt_pkg::SOCKETS - 1));
      if ($urandom_range(0, 15) == 0)
        p = smt_pkg::IDX_W'($urandom_range(smt_pkg::PORTS, IDX_MAX));
      else p = smt_pkg::IDX_W'($urandom_range(0, smt_pkg::PORTS - 1));
      if (s < gen_fill && $urandom_range(0, 9) < 8) who = gen_owner[s];
      else if ($urandom_range(0, 1) == 0) who = caller_pool[$urandom_range(0, 3)];
      else who = smt_pkg::CALLER_W'($urandom);
      if ($urandom_range(0, 15) == 0) msg = '0;
      else msg = $urandom;
      push_req(op, who, s, p, msg);
    end
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left == 0 && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        gap_left = $urandom_range(1, 8);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        next_req = req_q.pop_front();
        opcode       <= next_req.op;
        caller_id    <= next_req.who;
        socket_index <= next_req.sock;
        port_number  <= next_req.port;
        message_word <= next_req.msg;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stall_left == 0 && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took  = in_valid && in_ready;
      out_took = out_valid && out_ready;
      if (out_took) begin
        results++;
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d value %h", status_code, result_value);
        end else begin
          want = due_q.pop_front();
          if (status_code !== want.status || result_value !== want.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: status %0d (want %0d), value %h (want %h)",
                       results, status_code, want.status, result_value, want.value);
          end
        end
      end
      if (in_took) begin
        want = mailbox_table_apply(opcode, caller_id, socket_index, port_number, message_word);
        due_q.push_back(want);
        status_seen[want.status]++;
        accepted++;
      end
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    caller_pool[0] = 16'h0000;
    caller_pool[1] = 16'hFFFF;
    caller_pool[2] = 16'h5A3C;
    caller_pool[3] = smt_pkg::CALLER_W'($urandom);
    gap_odds = 3;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: errors on an empty table, then a small worked scenario
    push_req(smt_pkg::OP_RECEIVE, caller_pool[0], 0, 0, '0);
    push_req(smt_pkg::OP_SEND, caller_pool[0], smt_pkg::IDX_W'(IDX_MAX), 0, '0);
    push_req(smt_pkg::OP_W'(OP_MAX), caller_pool[1], 0, 0, '1);
    push_req(smt_pkg::OP_OPEN, caller_pool[0], 0, 0, '0);
    push_req(smt_pkg::OP_OPEN, caller_pool[1], 0, 0, '0);
    push_req(smt_pkg::OP_OPEN, caller_pool[2], 0, 0, '0);
    push_req(smt_pkg::OP_BIND, caller_pool[0], 0, 0, '0);
    push_req(smt_pkg::OP_BIND, caller_pool[1], 1, 0, '0);
    push_req(smt_pkg::OP_BIND, caller_pool[1], 1, smt_pkg::IDX_W'(IDX_MAX), '0);
    push_req(smt_pkg::OP_BIND, caller_pool[1], 1, smt_pkg::IDX_W'(smt_pkg::PORTS - 1), '0);
    push_req(smt_pkg::OP_CONNECT, caller_pool[2], 2, 3, '0);
    push_req(smt_pkg::OP_CONNECT, caller_pool[0], 0, smt_pkg::IDX_W'(smt_pkg::PORTS - 1), '0);
    push_req(smt_pkg::OP_CONNECT, caller_pool[2], 2, smt_pkg::IDX_W'(smt_pkg::PORTS - 1), '0);
    push_req(smt_pkg::OP_SEND, caller_pool[2], 2, 0, 32'h1);
    push_req(smt_pkg::OP_SEND, caller_pool[1], 0, 0, 32'h2);
    push_req(smt_pkg::OP_SEND, caller_pool[0], 0, 0, '1);
    push_req(smt_pkg::OP_SEND, caller_pool[0], 0, 0, 32'h3);
    push_req(smt_pkg::OP_SEND, caller_pool[1], 1, 0, '0);
    push_req(smt_pkg::OP_RECEIVE, caller_pool[0], 1, 0, '0);
    push_req(smt_pkg::OP_RECEIVE, caller_pool[1], 1, 0, '0);
    push_req(smt_pkg::OP_RECEIVE, caller_pool[1], 1, 0, '0);
    push_req(smt_pkg::OP_BIND, caller_pool[2], 2, 2, '0);
    push_req(smt_pkg::OP_CONNECT, caller_pool[2], 2, 2, '0);
    push_req(smt_pkg::OP_OPEN, caller_pool[0], 0, 0, '0);
    push_req(smt_pkg::OP_BIND, caller_pool[0], 3, 9, '0);
    push_req(smt_pkg::OP_CONNECT, caller_pool[0], 0, 9, '0);
    push_req(smt_pkg::OP_SEND, caller_pool[1], 1, 0, 32'hA5A5_0F0F);

    push_random(500);
    while (req_q.size() > 0) @(negedge clk);
    gap_odds = 0;
    push_random(200);

    // sender pause until the table has answered everything
    while (req_q.size() > 0 || in_valid || due_q.size() > 0) @(negedge clk);
    repeat ($urandom_range(5, 20)) @(negedge clk);
    gap_odds = 6;
    push_random(300);

    // long result stall while requests keep coming
    while (req_q.size() > 0) @(negedge clk);
    gap_odds = 4;
    hold_go = 1'b1;
    push_random(250);

    while (req_q.size() > 0) @(negedge clk);
    gap_odds = 0;
    push_random(280);

    while (req_q.size() > 0 || in_valid) @(negedge clk);
    while (due_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d items accepted, %0d results checked, %0d mismatches",
             accepted, results, mismatches);
    $display("status mix: ok %0d, bad index %0d, closed %0d, unpaired %0d, refused %0d, full %0d",
             status_seen[smt_pkg::ST_OK], status_seen[smt_pkg::ST_BAD_INDEX],
             status_seen[smt_pkg::ST_CLOSED], status_seen[smt_pkg::ST_NOT_CONNECTED],
             status_seen[smt_pkg::ST_REFUSED], status_seen[smt_pkg::ST_FULL]);
    if (due_q.size() > 0)
      $display("%0d results never arrived", due_q.size());
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/smt_pkg.sv
hw/rtl/smt_ctrl.sv
hw/rtl/smt_dp.sv
hw/rtl/socket_mailbox_table_top.sv
tb/socket_mailbox_table_top_test.sv
